>>> rtl/ahr_pkg.sv
// Package with shared widths, codes and types of the pulse-rate estimator.
package ahr_pkg;

    // Field widths
    localparam int SAMPLE_W   = 18;
    localparam int RATE_W     = 13;
    localparam int LAG_W      = 8;
    localparam int POS_W      = 10;

    // Parameter defaults
    localparam int WINDOW_LEN_DEF   = 150;
    localparam int HISTORY_LEN_DEF  = 5;
    localparam int UPDATE_EVERY_DEF = 50;

    // Arithmetic constants
    localparam int RATE_SCALE = 6000;
    localparam int VALID_MIN  = 3;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] BASELINE_RST = 18'd0;
    localparam logic [SAMPLE_W-1:0] FINGER_RST   = 18'd10000;
    localparam logic [RATE_W-1:0]   ALERT_RST    = 13'd90;
    localparam logic [LAG_W-1:0]    LAG_FIRST_RST = 8'd50;
    localparam logic [LAG_W-1:0]    LAG_END_RST   = 8'd120;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_BASELINE  = 3'd0,
        REG_FINGER    = 3'd1,
        REG_ALERT     = 3'd2,
        REG_LAG_FIRST = 3'd3,
        REG_LAG_END   = 3'd4
    } reg_index_t;

    // What the back end has to do with one item
    typedef enum logic [1:0] {
        CMD_PLAIN    = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_NOT_FULL = 2'd2,
        CMD_ESTIMATE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic             finger;
        logic [POS_W-1:0] pos;
    } cmd_t;

    typedef struct packed {
        logic est_done;
    } back_status_t;

endpackage

>>> rtl/ahr_ram.sv
// Generic RAM with one write port and two registered read ports.
module ahr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 150
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

>>> rtl/ahr_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ahr_div #(
    parameter int DW = 26
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // One shift and trial subtraction per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end
endmodule

>>> rtl/ahr_front.sv
// Front end: takes samples, fills the window and classifies each item.
module ahr_front #(
    parameter int WINDOW_LEN   = 150,
    parameter int UPDATE_EVERY = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ahr_pkg::SAMPLE_W-1:0]  ir_sample,
    input  logic [ahr_pkg::SAMPLE_W-1:0]  baseline_level,
    input  logic [ahr_pkg::SAMPLE_W-1:0]  finger_level,
    output logic                          ram_we,
    output logic [$clog2(WINDOW_LEN)-1:0] ram_waddr,
    output logic [ahr_pkg::SAMPLE_W-1:0]  ram_wdata,
    input  logic                          q_full,
    output logic                          q_push,
    output ahr_pkg::cmd_t                 q_cmd,
    input  ahr_pkg::back_status_t         status
);
    import ahr_pkg::*;

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int CW = $clog2(UPDATE_EVERY + 1);

    logic [AW-1:0]       pos_reg, pos_next;
    logic                full_reg, full_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [SAMPLE_W-1:0] corr;
    logic                finger;
    logic                accept;

    assign in_ready  = !q_full && !busy_reg;
    assign accept    = in_valid && in_ready;
    assign corr      = (ir_sample > baseline_level) ? ir_sample - baseline_level : '0;
    assign finger    = corr > finger_level;
    assign ram_we    = accept;
    assign ram_waddr = pos_reg;
    assign ram_wdata = corr;
    assign q_push    = accept;

    // Window bookkeeping and item classification
    always_comb
    begin
        pos_next  = pos_reg;
        full_next = full_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_cmd.kind   = CMD_PLAIN;
        q_cmd.finger = finger;
        if (status.est_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (32'(pos_reg) + 1 >= WINDOW_LEN)
            begin
                pos_next  = '0;
                full_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (32'(cnt_reg) + 1 >= UPDATE_EVERY)
            begin
                cnt_next = '0;
                if (finger)
                begin
                    if (full_next)
                    begin
                        q_cmd.kind = CMD_ESTIMATE;
                        busy_next  = 1'b1;
                    end
                    else
                    begin
                        q_cmd.kind = CMD_NOT_FULL;
                    end
                end
                else
                begin
                    q_cmd.kind = CMD_CLEAR;
                    pos_next   = '0;
                    full_next  = 1'b0;
                end
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        q_cmd.pos = POS_W'(pos_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            full_reg <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            full_reg <= full_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end
endmodule

>>> rtl/ahr_queue.sv
// Two-entry command queue between the front and back ends.
module ahr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ahr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output ahr_pkg::cmd_t head
);
    import ahr_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign valid = cnt_reg != 2'd0;
    assign head  = mem_reg[rd_reg];

    // Occupancy tracking
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && valid))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && pop && valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop && valid)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end
endmodule

>>> rtl/ahr_back.sv
// Back end: autocorrelation search, rate history and result register.
module ahr_back #(
    parameter int WINDOW_LEN  = 150,
    parameter int HISTORY_LEN = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  ahr_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic [$clog2(WINDOW_LEN)-1:0] raddr_a,
    output logic [$clog2(WINDOW_LEN)-1:0] raddr_b,
    input  logic [ahr_pkg::SAMPLE_W-1:0]  rdata_a,
    input  logic [ahr_pkg::SAMPLE_W-1:0]  rdata_b,
    input  logic [ahr_pkg::LAG_W-1:0]     lag_first,
    input  logic [ahr_pkg::LAG_W-1:0]     lag_end,
    input  logic [ahr_pkg::RATE_W-1:0]    alert_rate,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ahr_pkg::RATE_W-1:0]    rate_raw,
    output logic [ahr_pkg::RATE_W-1:0]    rate_smoothed,
    output logic                          finger_present,
    output logic                          reading_valid,
    output logic                          rate_alert,
    output ahr_pkg::back_status_t         status
);
    import ahr_pkg::*;

    localparam int AW     = $clog2(WINDOW_LEN);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN + 1);
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = PROD_W + $clog2(WINDOW_LEN + 1);
    localparam int HP_W   = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int HC_W   = $clog2(HISTORY_LEN + 1);
    localparam int HS_W   = RATE_W + HC_W;

    // Reciprocal of the window length, exact for every window sum
    localparam int MEAN_SH = SUM_W + $clog2(WINDOW_LEN);
    localparam int MUL_W   = SUM_W + 1;
    localparam int MP_W    = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] MEAN_MUL =
        MUL_W'(((64'd1 << MEAN_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_MEAN_DIV, S_LAG, S_MAC, S_RATE_DIV, S_HSUM, S_AVG_DIV, S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic                      finger_reg, finger_next;
    logic [AW-1:0]             pos_reg, pos_next;
    logic [AW-1:0]             i_reg, i_next;
    logic [LAG_W-1:0]          lag_reg, lag_next;
    logic                      issue_reg, issue_next;
    logic                      v1_reg, v1_next;
    logic                      v2_reg, v2_next;
    logic                      v3_reg, v3_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [SAMPLE_W-1:0]       mean_reg, mean_next;
    logic [MP_W-1:0]           mean_prod;
    logic signed [DIFF_W-1:0]  da_reg, da_next;
    logic signed [DIFF_W-1:0]  db_reg, db_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   best_reg, best_next;
    logic [LAG_W-1:0]          peak_lag_reg, peak_lag_next;
    logic [RATE_W-1:0]         raw_reg, raw_next;
    logic [RATE_W-1:0]         sm_reg, sm_next;
    logic [RATE_W-1:0]         hist_reg [HISTORY_LEN];
    logic                      hist_we;
    logic [HP_W-1:0]           hpos_reg, hpos_next;
    logic [HC_W-1:0]           hcnt_reg, hcnt_next;
    logic [HC_W-1:0]           k_reg, k_next;
    logic [HS_W-1:0]           hsum_reg, hsum_next;
    logic [HP_W-1:0]           hidx;
    logic                      out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]         o_raw_reg, o_sm_reg;
    logic                      o_finger_reg, o_valid_reg, o_alert_reg;
    logic                      load_out;
    logic                      div_start;
    logic [SUM_W-1:0]          div_a, div_b;
    logic                      div_done;
    logic [SUM_W-1:0]          div_q;
    logic                      done_pulse;
    int                        ia, ib, hi;

    ahr_div #(.DW(SUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid      = out_valid_reg;
    assign rate_raw       = o_raw_reg;
    assign rate_smoothed  = o_sm_reg;
    assign finger_present = o_finger_reg;
    assign reading_valid  = o_valid_reg;
    assign rate_alert     = o_alert_reg;
    assign status.est_done = done_pulse;

    // Window sum times the reciprocal of the window length
    assign mean_prod = MP_W'(sum_reg) * MP_W'(MEAN_MUL);

    // Window addresses, oldest sample first, folded into the ring
    always_comb
    begin
        ia = 32'(pos_reg) + 32'(i_reg);
        ib = ia + 32'(lag_reg);
        if (ia >= WINDOW_LEN)
        begin
            ia = ia - WINDOW_LEN;
        end
        if (ib >= WINDOW_LEN)
        begin
            ib = ib - WINDOW_LEN;
        end
        raddr_a = AW'(ia);
        raddr_b = AW'(ib);
        hi = 32'(hpos_reg) + HISTORY_LEN - 1 - 32'(k_reg);
        if (hi >= HISTORY_LEN)
        begin
            hi = hi - HISTORY_LEN;
        end
        hidx = HP_W'(hi);
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        finger_next   = finger_reg;
        pos_next      = pos_reg;
        i_next        = i_reg;
        lag_next      = lag_reg;
        issue_next    = issue_reg;
        v1_next       = 1'b0;
        v2_next       = v1_reg;
        v3_next       = v2_reg;
        sum_next      = sum_reg;
        mean_next     = mean_reg;
        da_next       = $signed({1'b0, rdata_a}) - $signed({1'b0, mean_reg});
        db_next       = $signed({1'b0, rdata_b}) - $signed({1'b0, mean_reg});
        prod_next     = da_reg * db_reg;
        acc_next      = acc_reg;
        best_next     = best_reg;
        peak_lag_next = peak_lag_reg;
        raw_next      = raw_reg;
        sm_next       = sm_reg;
        hist_we       = 1'b0;
        hpos_next     = hpos_reg;
        hcnt_next     = hcnt_reg;
        k_next        = k_reg;
        hsum_next     = hsum_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        div_a         = '0;
        div_b         = '0;
        load_out      = 1'b0;
        done_pulse    = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    finger_next = q_cmd.finger;
                    pos_next    = AW'(q_cmd.pos);
                    state_next  = S_EMIT;
                    case (q_cmd.kind)
                        CMD_PLAIN:
                        begin
                        end
                        CMD_CLEAR:
                        begin
                            raw_next  = '0;
                            sm_next   = '0;
                            hcnt_next = '0;
                        end
                        CMD_NOT_FULL:
                        begin
                            raw_next = '0;
                        end
                        CMD_ESTIMATE:
                        begin
                            i_next     = '0;
                            issue_next = 1'b1;
                            sum_next   = '0;
                            state_next = S_SUM;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SUM:
            begin
                // Sum of the whole window for the mean
                v1_next = issue_reg;
                if (issue_reg)
                begin
                    if (32'(i_reg) == WINDOW_LEN - 1)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                if (v1_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rdata_a);
                end
                if (!issue_reg && !v1_reg)
                begin
                    state_next = S_MEAN_DIV;
                end
            end
            S_MEAN_DIV:
            begin
                // Mean of the window in one multiply
                mean_next     = mean_prod[MEAN_SH +: SAMPLE_W];
                lag_next      = (lag_first == '0) ? LAG_W'(1) : lag_first;
                best_next     = '0;
                peak_lag_next = '0;
                state_next    = S_LAG;
            end
            S_LAG:
            begin
                if (lag_reg < lag_end && 32'(lag_reg) < WINDOW_LEN)
                begin
                    i_next     = '0;
                    issue_next = 1'b1;
                    acc_next   = '0;
                    state_next = S_MAC;
                end
                else if (peak_lag_reg == '0)
                begin
                    raw_next   = '0;
                    done_pulse = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = SUM_W'(RATE_SCALE);
                    div_b      = SUM_W'(peak_lag_reg);
                    state_next = S_RATE_DIV;
                end
            end
            S_MAC:
            begin
                // Read, subtract mean, multiply, accumulate
                v1_next = issue_reg;
                if (issue_reg)
                begin
                    if (32'(i_reg) + 32'(lag_reg) == WINDOW_LEN - 1)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                if (v3_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (!issue_reg && !v1_reg && !v2_reg && !v3_reg)
                begin
                    if (acc_reg > best_reg)
                    begin
                        best_next     = acc_reg;
                        peak_lag_next = lag_reg;
                    end
                    lag_next   = lag_reg + 1'b1;
                    state_next = S_LAG;
                end
            end
            S_RATE_DIV:
            begin
                if (div_done)
                begin
                    raw_next = div_q[RATE_W-1:0];
                    if (div_q[RATE_W-1:0] == '0)
                    begin
                        done_pulse = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        hist_we   = 1'b1;
                        hpos_next = (32'(hpos_reg) + 1 >= HISTORY_LEN) ? '0 : hpos_reg + 1'b1;
                        if (32'(hcnt_reg) < HISTORY_LEN)
                        begin
                            hcnt_next = hcnt_reg + 1'b1;
                        end
                        k_next     = '0;
                        hsum_next  = '0;
                        state_next = S_HSUM;
                    end
                end
            end
            S_HSUM:
            begin
                // Sum of the most recent history entries
                hsum_next = hsum_reg + HS_W'(hist_reg[hidx]);
                k_next    = k_reg + 1'b1;
                if (k_reg == hcnt_reg - 1'b1)
                begin
                    div_start  = 1'b1;
                    div_a      = SUM_W'(hsum_next);
                    div_b      = SUM_W'(hcnt_reg);
                    state_next = S_AVG_DIV;
                end
            end
            S_AVG_DIV:
            begin
                if (div_done)
                begin
                    sm_next    = div_q[RATE_W-1:0];
                    done_pulse = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            raw_reg       <= '0;
            sm_reg        <= '0;
            hpos_reg      <= '0;
            hcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            raw_reg       <= raw_next;
            sm_reg        <= sm_next;
            hpos_reg      <= hpos_next;
            hcnt_reg      <= hcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        finger_reg   <= finger_next;
        pos_reg      <= pos_next;
        i_reg        <= i_next;
        lag_reg      <= lag_next;
        sum_reg      <= sum_next;
        mean_reg     <= mean_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        peak_lag_reg <= peak_lag_next;
        k_reg        <= k_next;
        hsum_reg     <= hsum_next;
        if (hist_we)
        begin
            hist_reg[hpos_reg] <= raw_next;
        end
        if (load_out)
        begin
            o_raw_reg    <= raw_reg;
            o_sm_reg     <= sm_reg;
            o_finger_reg <= finger_reg;
            o_valid_reg  <= 32'(hcnt_reg) >= VALID_MIN;
            o_alert_reg  <= (32'(hcnt_reg) >= VALID_MIN) && finger_reg && (sm_reg > alert_rate);
        end
    end
endmodule

>>> rtl/autocorrelation_heart_rate_top.sv
// Top level of the autocorrelation pulse-rate estimator.
// A sample that starts no estimate gives its result transaction through the
// queue and the back end's emit state. At every estimate the block sums the
// window, takes the mean in one multiply, then runs one multiply-accumulate
// per cycle through the window RAM's two read ports, with a setup state for
// each lag searched, followed by up to two serial divisions with the history
// entries summed between them. The sample port stays stalled during that
// time, and the two-entry queue lets a couple of samples wait while the
// result register is held.
module autocorrelation_heart_rate_top #(
    parameter int WINDOW_LEN   = ahr_pkg::WINDOW_LEN_DEF,
    parameter int HISTORY_LEN  = ahr_pkg::HISTORY_LEN_DEF,
    parameter int UPDATE_EVERY = ahr_pkg::UPDATE_EVERY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // ir_sample[17:0], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // rate_raw[12:0], rate_smoothed[25:13],
                                        // finger_present[26], reading_valid[27],
                                        // rate_alert[28], zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ahr_pkg::*;

    localparam int AW = $clog2(WINDOW_LEN);

    logic [SAMPLE_W-1:0] baseline_reg, finger_reg;
    logic [RATE_W-1:0]   alert_reg;
    logic [LAG_W-1:0]    lag_first_reg, lag_end_reg;
    logic                cfg_wr;
    reg_index_t          cfg_idx;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, raddr_a, raddr_b;
    logic [SAMPLE_W-1:0] ram_wdata, rdata_a, rdata_b;
    logic                q_full, q_push, q_pop, q_valid;
    cmd_t                push_cmd, head_cmd;
    back_status_t        status;
    logic [RATE_W-1:0]   rate_raw, rate_smoothed;
    logic                finger_present, reading_valid, rate_alert;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= BASELINE_RST;
            finger_reg    <= FINGER_RST;
            alert_reg     <= ALERT_RST;
            lag_first_reg <= LAG_FIRST_RST;
            lag_end_reg   <= LAG_END_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BASELINE:  baseline_reg  <= pwdata[SAMPLE_W-1:0];
                REG_FINGER:    finger_reg    <= pwdata[SAMPLE_W-1:0];
                REG_ALERT:     alert_reg     <= pwdata[RATE_W-1:0];
                REG_LAG_FIRST: lag_first_reg <= pwdata[LAG_W-1:0];
                REG_LAG_END:   lag_end_reg   <= pwdata[LAG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (cfg_idx)
            REG_BASELINE:  prdata = 32'(baseline_reg);
            REG_FINGER:    prdata = 32'(finger_reg);
            REG_ALERT:     prdata = 32'(alert_reg);
            REG_LAG_FIRST: prdata = 32'(lag_first_reg);
            REG_LAG_END:   prdata = 32'(lag_end_reg);
            default:       prdata = '0;
        endcase
    end

    ahr_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_LEN)) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    ahr_front #(.WINDOW_LEN(WINDOW_LEN), .UPDATE_EVERY(UPDATE_EVERY)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .ir_sample      (s_axis_tdata[SAMPLE_W-1:0]),
        .baseline_level (baseline_reg),
        .finger_level   (finger_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd),
        .status         (status)
    );

    ahr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    ahr_back #(.WINDOW_LEN(WINDOW_LEN), .HISTORY_LEN(HISTORY_LEN)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (head_cmd),
        .q_pop          (q_pop),
        .raddr_a        (raddr_a),
        .raddr_b        (raddr_b),
        .rdata_a        (rdata_a),
        .rdata_b        (rdata_b),
        .lag_first      (lag_first_reg),
        .lag_end        (lag_end_reg),
        .alert_rate     (alert_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .rate_raw       (rate_raw),
        .rate_smoothed  (rate_smoothed),
        .finger_present (finger_present),
        .reading_valid  (reading_valid),
        .rate_alert     (rate_alert),
        .status         (status)
    );

    assign m_axis_tdata = {3'b000, rate_alert, reading_valid, finger_present,
                           rate_smoothed, rate_raw};

`ifndef ASSERT_OFF
    // A finished estimate must not coincide with a sample transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.est_done |-> !(s_axis_tvalid && s_axis_tready))
        else $error("sample taken while an estimate finished");

    // A valid reading averages nonzero rates, so the smoothed rate is nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && reading_valid |-> rate_smoothed != '0)
        else $error("valid reading with zero smoothed rate");

    // An alert needs a valid reading and a finger.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && rate_alert |-> reading_valid && finger_present)
        else $error("alert without valid reading and finger");
`endif
endmodule

>>> test/ahr_checker.sv
// Checker of the pulse-rate estimator: predicts every result and compares it.
module ahr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    import ahr_pkg::*;

    localparam int WIN   = WINDOW_LEN_DEF;
    localparam int HIST  = HISTORY_LEN_DEF;
    localparam int EVERY = UPDATE_EVERY_DEF;

    typedef struct packed {
        logic [RATE_W-1:0] raw;
        logic [RATE_W-1:0] smoothed;
        logic              finger;
        logic              valid;
        logic              alert;
    } rate_result_t;

    // Register copies
    logic [SAMPLE_W-1:0] baseline;
    logic [SAMPLE_W-1:0] finger_lvl;
    logic [RATE_W-1:0]   alert_lvl;
    logic [LAG_W-1:0]    lag_lo;
    logic [LAG_W-1:0]    lag_hi;

    // Estimator state
    logic [SAMPLE_W-1:0] window_mem [WIN];
    int                  wpos;
    bit                  wfull;
    int                  interval;
    logic [RATE_W-1:0]   history [HIST];
    int                  hpos;
    int                  hcount;
    logic [RATE_W-1:0]   raw_rate;
    logic [RATE_W-1:0]   smooth_rate;

    rate_result_t expected_rates[$];

    // Autocorrelation over the window, oldest sample first.
    function automatic int unsigned pulse_rate_from_window();
        longint total;
        longint mean;
        longint best;
        longint acc;
        longint a;
        longint b;
        int     lo;
        int     peak_lag;
        total = 0;
        best = 0;
        peak_lag = 0;
        if (!wfull)
            return 0;
        for (int i = 0; i < WIN; i++)
            total += window_mem[(wpos + i) % WIN];
        mean = total / WIN;
        lo = (lag_lo == 0) ? 1 : int'(lag_lo);
        for (int lag = lo; lag < int'(lag_hi) && lag < WIN; lag++)
        begin
            acc = 0;
            for (int i = 0; i + lag < WIN; i++)
            begin
                a = longint'(window_mem[(wpos + i) % WIN]) - mean;
                b = longint'(window_mem[(wpos + i + lag) % WIN]) - mean;
                acc += a * b;
            end
            if (acc > best)
            begin
                best = acc;
                peak_lag = lag;
            end
        end
        if (peak_lag == 0)
            return 0;
        return RATE_SCALE / peak_lag;
    endfunction

    // Enters one rate into the history and returns the mean of recent entries.
    function automatic logic [RATE_W-1:0] history_mean(input logic [RATE_W-1:0] rate);
        longint sum;
        sum = 0;
        history[hpos] = rate;
        hpos = (hpos + 1) % HIST;
        if (hcount < HIST)
            hcount++;
        for (int k = 0; k < hcount; k++)
            sum += history[(hpos + HIST - 1 - k) % HIST];
        return RATE_W'(sum / hcount);
    endfunction

    // Advances the state by one sample and returns the result it causes.
    function automatic rate_result_t predict_sample(input logic [SAMPLE_W-1:0] ir);
        logic [SAMPLE_W-1:0] corr;
        bit                  finger;
        bit                  valid;
        rate_result_t        r;
        corr = (ir > baseline) ? ir - baseline : '0;
        finger = corr > finger_lvl;
        window_mem[wpos] = corr;
        wpos++;
        if (wpos >= WIN)
        begin
            wpos = 0;
            wfull = 1;
        end
        interval++;
        if (interval >= EVERY)
        begin
            interval = 0;
            if (finger)
            begin
                raw_rate = RATE_W'(pulse_rate_from_window());
                if (raw_rate > 0)
                    smooth_rate = history_mean(raw_rate);
            end
            else
            begin
                raw_rate = '0;
                smooth_rate = '0;
                hcount = 0;
                wfull = 0;
                wpos = 0;
            end
        end
        valid = hcount >= VALID_MIN;
        r.raw = raw_rate;
        r.smoothed = smooth_rate;
        r.finger = finger;
        r.valid = valid;
        r.alert = valid && finger && (smooth_rate > alert_lvl);
        return r;
    endfunction

    // Register writes, sample transactions and result transactions.
    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t got;
        rate_result_t want;
        if (!rst_n)
        begin
            baseline = BASELINE_RST;
            finger_lvl = FINGER_RST;
            alert_lvl = ALERT_RST;
            lag_lo = LAG_FIRST_RST;
            lag_hi = LAG_END_RST;
            for (int i = 0; i < WIN; i++)
                window_mem[i] = '0;
            for (int i = 0; i < HIST; i++)
                history[i] = '0;
            wpos = 0;
            wfull = 0;
            interval = 0;
            hpos = 0;
            hcount = 0;
            raw_rate = '0;
            smooth_rate = '0;
            expected_rates.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_BASELINE:  baseline = pwdata[SAMPLE_W-1:0];
                    REG_FINGER:    finger_lvl = pwdata[SAMPLE_W-1:0];
                    REG_ALERT:     alert_lvl = pwdata[RATE_W-1:0];
                    REG_LAG_FIRST: lag_lo = pwdata[LAG_W-1:0];
                    REG_LAG_END:   lag_hi = pwdata[LAG_W-1:0];
                    default:       ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_rates.push_back(predict_sample(s_axis_tdata[SAMPLE_W-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.raw = m_axis_tdata[12:0];
                got.smoothed = m_axis_tdata[25:13];
                got.finger = m_axis_tdata[26];
                got.valid = m_axis_tdata[27];
                got.alert = m_axis_tdata[28];
                if (expected_rates.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %h", m_axis_tdata);
                end
                else
                begin
                    want = expected_rates.pop_front();
                    if (got !== want || m_axis_tdata[31:29] !== 3'd0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: raw %0d/%0d smoothed %0d/%0d finger %0d/%0d",
                                      " valid %0d/%0d alert %0d/%0d (expected/actual)"},
                                     want.raw, got.raw, want.smoothed, got.smoothed,
                                     want.finger, got.finger, want.valid, got.valid,
                                     want.alert, got.alert);
                    end
                end
            end
            pending = expected_rates.size();
        end
    end

endmodule

>>> test/tb_autocorrelation_heart_rate_top.sv
// Testbench top of the pulse-rate estimator: clock, reset, stimulus and verdict.
module tb_autocorrelation_heart_rate_top;
    import ahr_pkg::*;

    localparam int SPARE_INDEX = 6;
    localparam int SAMPLE_MAX  = 262143;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          sent;
    logic [SAMPLE_W-1:0] cur_baseline;
    logic [SAMPLE_W-1:0] cur_finger;

    autocorrelation_heart_rate_top DUT (.*);

    ahr_checker checker_i (.*);

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #60000000;
        $display("simulation failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: ready bursts separated by stalls.
    initial
    begin
        int n;
        int g;
        m_axis_tready = 1;
        forever
        begin
            n = $urandom_range(1, 40);
            m_axis_tready = 1;
            repeat (n) @(negedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                m_axis_tready = 0;
                repeat (g) @(negedge clk);
            end
        end
    end

    // Sends one sample transaction; returns at the falling edge after acceptance.
    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit no_gaps);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0)
        begin
            s_axis_tvalid = 0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {6'd0, v};
        // Ready only changes at rising edges, so it is stable here.
        while (!s_axis_tready)
            @(negedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Waits until every result is back and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input int idx, input logic [31:0] v);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = 5'(idx * 4);
        pwdata = v;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        if (idx == REG_BASELINE)
            cur_baseline = v[SAMPLE_W-1:0];
        if (idx == REG_FINGER)
            cur_finger = v[SAMPLE_W-1:0];
    endtask

    // Random settings for one phase, extremes included now and then.
    task automatic random_settings();
        int lo;
        int hi;
        int r;
        r = $urandom_range(0, 9);
        write_reg(REG_BASELINE, r == 0 ? SAMPLE_MAX : (r < 3 ? 0 : $urandom_range(0, 20000)));
        r = $urandom_range(0, 9);
        write_reg(REG_FINGER, r == 0 ? SAMPLE_MAX : (r < 2 ? 0 : $urandom_range(0, 30000)));
        r = $urandom_range(0, 9);
        write_reg(REG_ALERT, r == 0 ? 8191 : (r == 1 ? 0 : (r == 2 ? 6000
                                                            : $urandom_range(40, 130))));
        r = $urandom_range(0, 9);
        lo = r == 0 ? 0 : (r == 1 ? 1 : (r == 2 ? 149 : (r == 3 ? 255
                                                         : $urandom_range(20, 80))));
        write_reg(REG_LAG_FIRST, lo);
        r = $urandom_range(0, 9);
        if (r == 0)
            hi = 255;
        else if (r == 1)
            hi = 150;
        else if (r == 2)
            hi = lo > 2 ? $urandom_range(0, lo) : 0;
        else
            hi = lo < 149 ? $urandom_range(lo + 1, 150) : 150;
        write_reg(REG_LAG_END, hi);
    endtask

    // One phase of a periodic pulse shape with noise, dips and stray samples.
    task automatic pulse_phase(input int count);
        int     period;
        int     amp;
        int     offs;
        int     t;
        int     tri_v;
        int     v;
        int     r;
        bit     no_gaps;
        period = $urandom_range(30, 150);
        amp = $urandom_range(2000, 40000);
        offs = cur_baseline + cur_finger + $urandom_range(1000, 5000);
        no_gaps = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < count; i++)
        begin
            t = i % period;
            tri_v = t < period / 2 ? t : period - t;
            v = offs + amp * tri_v * 2 / period + $urandom_range(0, 300);
            r = $urandom_range(0, 99);
            if (r < 2)
                v = $urandom_range(0, SAMPLE_MAX);
            else if (r < 4)
                v = $urandom_range(0, cur_baseline);
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            send_sample(SAMPLE_W'(v), no_gaps);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [SAMPLE_W-1:0] edge_samples [10];
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        cur_baseline = BASELINE_RST;
        cur_finger = FINGER_RST;
        rst_n = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed part: field extremes and samples around the baseline.
        write_reg(SPARE_INDEX, 32'hFFFF_FFFF);
        write_reg(REG_BASELINE, 1000);
        edge_samples = '{18'd0, 18'd999, 18'd1000, 18'd1001, 18'h3FFFF,
                         18'h2AAAA, 18'h15555, 18'd11000, 18'd11001, 18'd11002};
        for (int i = 0; i < 10; i++)
            send_sample(edge_samples[i], 0);
        wait_idle();
        write_reg(REG_BASELINE, 0);
        for (int i = 0; i < 15; i++)
            send_sample(i % 2 ? 18'h3FFFF : 18'd0, 1);
        wait_idle();

        // First a phase with the reset settings, then random ones.
        pulse_phase(400);
        while (sent < 1600)
        begin
            wait_idle();
            random_settings();
            pulse_phase($urandom_range(100, 300));
        end

        wait_idle();
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> autocorrelation_heart_rate_top.f
rtl/ahr_pkg.sv
rtl/ahr_ram.sv
rtl/ahr_div.sv
rtl/ahr_front.sv
rtl/ahr_queue.sv
rtl/ahr_back.sv
rtl/autocorrelation_heart_rate_top.sv
test/ahr_checker.sv
test/tb_autocorrelation_heart_rate_top.sv
